@@ rtl/core/substring_match_top_defines.svh @@
// Assertion macros shared by the substring matcher checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SUBSTRING_MATCH_TOP_DEFINES_SVH
`define SUBSTRING_MATCH_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMATCH_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMATCH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/smatch_pkg.sv @@
// Shared types and constants for the substring matcher.
// No dependencies; imported by every module of the block.
package smatch_pkg;

    localparam int DATA_W = 8;

    // Operation codes carried in the op field of an input word.
    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

    // One input word as held in the input register.
    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] data;
        logic              last;
    } smatch_item_t;

endpackage

@@ rtl/core/smatch_pattern.sv @@
// Pattern store: a shift line of pattern bytes, a length mask and the load state.
// Depends on smatch_pkg.
module smatch_pattern #(
    parameter int MAX_LEN = 64,
    localparam int LEN_W = $clog2(MAX_LEN + 1)
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          step,
    input  smatch_pkg::smatch_item_t                      item,
    output logic [MAX_LEN-1:0][smatch_pkg::DATA_W-1:0]    pat,
    output logic [MAX_LEN-1:0]                            mask,
    output logic [LEN_W-1:0]                              len
);
    import smatch_pkg::*;

    // The newest pattern byte sits at index 0, so entry j lines up with
    // window entry j once the whole pattern is loaded.
    logic [MAX_LEN-1:0][DATA_W-1:0] pat_reg, pat_next;
    logic [MAX_LEN-1:0]             mask_reg, mask_next;
    logic [LEN_W-1:0]               len_reg, len_next;
    logic                           open_reg, open_next;
    logic [LEN_W-1:0]               len_base;
    logic [MAX_LEN-1:0]             mask_base;

    always_comb begin
        pat_next  = pat_reg;
        mask_next = mask_reg;
        len_next  = len_reg;
        open_next = open_reg;
        // A byte arriving with no pattern open starts a fresh pattern.
        len_base  = open_reg ? len_reg : '0;
        mask_base = open_reg ? mask_reg : '0;
        if (step) begin
            if (item.op == OP_TEXT) begin
                open_next = 1'b0;
            end else begin
                len_next  = len_base;
                mask_next = mask_base;
                if (len_base < LEN_W'(MAX_LEN)) begin
                    pat_next  = {pat_reg[MAX_LEN-2:0], item.data};
                    mask_next = {mask_base[MAX_LEN-2:0], 1'b1};
                    len_next  = len_base + LEN_W'(1);
                end
                open_next = !item.last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
            len_reg  <= '0;
            open_reg <= 1'b0;
        end else begin
            mask_reg <= mask_next;
            len_reg  <= len_next;
            open_reg <= open_next;
        end
    end

    always_ff @(posedge aclk) begin
        pat_reg <= pat_next;
    end

    assign pat  = pat_reg;
    assign mask = mask_reg;
    assign len  = len_reg;

endmodule

@@ rtl/core/smatch_window.sv @@
// Text window: shift line of text bytes, parallel compare and sticky match flag.
// Depends on smatch_pkg.
module smatch_window #(
    parameter int MAX_LEN = 64,
    localparam int LEN_W = $clog2(MAX_LEN + 1)
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          step,
    input  smatch_pkg::smatch_item_t                      item,
    input  logic [MAX_LEN-1:0][smatch_pkg::DATA_W-1:0]    pat,
    input  logic [MAX_LEN-1:0]                            mask,
    input  logic [LEN_W-1:0]                              plen,
    output logic                                          result,
    output logic                                          found
);
    import smatch_pkg::*;

    // Entries at or above the text count are never compared, so the window
    // itself needs no clearing between texts.
    logic [MAX_LEN-1:0][DATA_W-1:0] win_reg, win_next, win_shift;
    logic [LEN_W-1:0]               cnt_reg, cnt_next, cnt_inc;
    logic                           seen_reg, seen_next, seen_any;
    logic [MAX_LEN-1:0]             ok;
    logic                           hit, text_step;

    always_comb begin
        win_shift = {win_reg[MAX_LEN-2:0], item.data};
        cnt_inc   = (cnt_reg < LEN_W'(MAX_LEN)) ? cnt_reg + LEN_W'(1) : cnt_reg;
        for (int j = 0; j < MAX_LEN; j++) begin
            ok[j] = !mask[j] || (win_shift[j] == pat[j]);
        end
        hit       = (plen == '0) || ((cnt_inc >= plen) && (&ok));
        seen_any  = seen_reg || hit;
        text_step = step && (item.op == OP_TEXT);

        win_next  = win_reg;
        cnt_next  = cnt_reg;
        seen_next = seen_reg;
        if (text_step) begin
            win_next = win_shift;
            if (item.last) begin
                cnt_next  = '0;
                seen_next = 1'b0;
            end else begin
                cnt_next  = cnt_inc;
                seen_next = seen_any;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            seen_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    assign result = text_step && item.last;
    assign found  = seen_any;

endmodule

@@ rtl/core/substring_match_top.sv @@
// Substring matcher: streams text words against a stored pattern of up to MAX_LEN bytes.
// Result path: input register, then output register, which holds the found word.
// Throughput: one input word per cycle; a last text word waits while a result stalls.
// Reset (synchronous, active low) empties the pattern, which then matches any text,
// and clears the text state; the pattern bytes themselves are not cleared.
// Depends on smatch_pkg, smatch_pattern and smatch_window.
module substring_match_top #(
    parameter int MAX_LEN = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic [smatch_pkg::DATA_W-1:0]     s_data,
    input  logic                              s_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_found
);
    import smatch_pkg::*;

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    // Input register. Every accepted word lands here first; once it advances it is
    // applied to the pattern store or the text window in one pass.
    smatch_item_t s1_item_reg, s1_item_next;
    logic         s1_vld_reg, s1_vld_next;

    // Output register. It holds a finished result while the consumer stalls, and
    // the input side keeps taking words meanwhile, up to the next last text word.
    logic         m_valid_reg, m_valid_next;
    logic         m_found_reg, m_found_next;

    logic         s1_is_result;
    logic         advance;
    logic         accept;

    logic [MAX_LEN-1:0][DATA_W-1:0] pat;
    logic [MAX_LEN-1:0]             mask;
    logic [LEN_W-1:0]               plen;
    logic                           result;
    logic                           found;

    // Only the last text word produces a result, so only it can be held back
    // by a full output register. Pattern words and other text words always
    // move on, so the input side runs at one word per cycle while no result is held back.
    assign s1_is_result = (s1_item_reg.op == OP_TEXT) && s1_item_reg.last;
    assign advance      = s1_vld_reg && (!s1_is_result || !m_valid_reg || m_ready);
    assign s_ready      = !s1_vld_reg || advance;
    assign accept       = s_valid && s_ready;

    always_comb begin
        s1_item_next = s1_item_reg;
        s1_vld_next  = s1_vld_reg;
        if (accept) begin
            s1_item_next = '{op: s_op, data: s_data, last: s_last};
            s1_vld_next  = 1'b1;
        end else if (advance) begin
            s1_vld_next  = 1'b0;
        end

        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        if (result) begin
            m_valid_next = 1'b1;
            m_found_next = found;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            s1_vld_reg  <= s1_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_item_reg <= s1_item_next;
        m_found_reg <= m_found_next;
    end

    // The pattern is kept newest byte first, aligned with the text window,
    // so every compare lane looks at a fixed pair of entries.
    smatch_pattern #(
        .MAX_LEN (MAX_LEN)
    ) u_pattern (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (s1_item_reg),
        .pat     (pat),
        .mask    (mask),
        .len     (plen)
    );

    // The window compares all lanes at once against the byte being shifted
    // in, folds the outcome into the sticky flag and reports on the last word.
    smatch_window #(
        .MAX_LEN (MAX_LEN)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (s1_item_reg),
        .pat     (pat),
        .mask    (mask),
        .plen    (plen),
        .result  (result),
        .found   (found)
    );

    assign m_valid = m_valid_reg;
    assign m_found = m_found_reg;

endmodule

@@ rtl/core/smatch_checker.sv @@
// Port-level checker for the substring matcher, bound to the top level.
// Depends on smatch_pkg and substring_match_top_defines.svh.
`include "substring_match_top_defines.svh"

module smatch_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_op,
    input logic s_last,
    input logic m_valid,
    input logic m_ready,
    input logic m_found
);
    import smatch_pkg::*;

    // A stalled result word holds its value.
    `SMATCH_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_found), "result word changed while stalled")

    // The input side is never blocked while the output register is empty.
    `SMATCH_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready, "input stalled with empty output")

    // A fresh result must follow an accepted last text word.
    `SMATCH_ASSERT_NOW(a_result_source, aclk, aresetn, $rose(m_valid), $past(aresetn && s_valid && s_ready && (s_op == OP_TEXT) && s_last, 2), "result without a closing text word")

endmodule

bind substring_match_top smatch_checker u_smatch_checker (.*);
